>>> design/vertex_project_to_window_top_defines.svh
// ----------------------------------------------------------------------------
// vertex_project_to_window assertion macros
// Shared concurrent assertion forms, clocked on aclk and held off in reset.
// ----------------------------------------------------------------------------
`ifndef VERTEX_PROJECT_TO_WINDOW_TOP_DEFINES_SVH
`define VERTEX_PROJECT_TO_WINDOW_TOP_DEFINES_SVH

// same-cycle implication
`define VPTW_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define VPTW_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/vptw_pkg.sv
// ----------------------------------------------------------------------------
// vptw_pkg
// Types and fixed constants shared by the vertex projection pipeline.
// ----------------------------------------------------------------------------
package vptw_pkg;

    localparam int ADDR_W    = 6;   // 7 registers at 8-byte spacing
    localparam int DATA_W    = 64;
    localparam int OUT_W     = 32;
    localparam int SIZE_W    = 16;  // viewport width / height
    localparam int FRAC_BITS = 16;  // Q16.16
    localparam int HALF_SH   = 15;  // scaled term carries 2^15
    localparam int QUOT_W    = 41;  // term saturates at 2^40
    localparam int NUM_SHIFT = QUOT_W - HALF_SH;
    localparam int DIV_STAGES = QUOT_W + 1;
    localparam int EPS_W     = 16;
    localparam int EPS_SH    = 12;

    localparam logic [QUOT_W-1:0] TERM_CAP = {1'b1, {(QUOT_W-1){1'b0}}};

    typedef enum logic [2:0] {
        REG_ROW0   = 3'd0,
        REG_ROW1   = 3'd1,
        REG_ROW2   = 3'd2,
        REG_ROW3   = 3'd3,
        REG_ORIGIN = 3'd4,
        REG_SIZE   = 3'd5,
        REG_WEPS   = 3'd6
    } cfg_reg_t;

    typedef struct packed {
        logic [OUT_W-1:0] screen_x;
        logic [OUT_W-1:0] screen_y;
        logic [OUT_W-1:0] window_depth;
        logic             projected_ok;
    } result_t;

endpackage

>>> design/vertex_project_to_window_top.sv
// ----------------------------------------------------------------------------
// vertex_project_to_window_top
// Object-space point to window coordinates through a 4x4 Q4.12 matrix.
// ----------------------------------------------------------------------------
// Takes one Q16.16 point (x,y,z) per item, forms clip coordinates with the
// loaded matrix (projection times model-view), divides x, y and z by w, maps
// [-1,1] to [0,1] and applies the viewport to x and y. Results come back as
// saturated Q16.16 window x, y and depth. If |w| is at or below w_epsilon
// (Q0.16) the item returns projected_ok = 0 with all coordinates zero.
// Throughput is one item per clock while s_ready is high. Each item passes
// 48 registers, the first loaded at acceptance: four arithmetic stages
// (input, multiply, sum, magnitude), one size multiply, 42 divider stages
// (overflow check plus one quotient bit per stage) and the output buffer.
// The output buffer holds two items, so input keeps flowing while one
// result waits; s_ready drops only while both entries are full. Registers
// (APB, 64-bit data, byte address 8*index): matrix rows 0..3, viewport
// origin, viewport size, w_epsilon. Write configuration only while the
// pipeline is empty.
// ----------------------------------------------------------------------------
`include "vertex_project_to_window_top_defines.svh"

module vertex_project_to_window_top #(
    parameter int COORD_WIDTH = 32,
    parameter int COEFF_WIDTH = 16
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // configuration
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [vptw_pkg::ADDR_W-1:0]        paddr,
    input  logic [vptw_pkg::DATA_W-1:0]        pwdata,
    output logic [vptw_pkg::DATA_W-1:0]        prdata,
    output logic                               pready,
    // input items
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic signed [COORD_WIDTH-1:0]      s_point_x,
    input  logic signed [COORD_WIDTH-1:0]      s_point_y,
    input  logic signed [COORD_WIDTH-1:0]      s_point_z,
    // result items
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic signed [vptw_pkg::OUT_W-1:0]  m_screen_x,
    output logic signed [vptw_pkg::OUT_W-1:0]  m_screen_y,
    output logic signed [vptw_pkg::OUT_W-1:0]  m_window_depth,
    output logic                               m_projected_ok
);

    localparam int CW      = COORD_WIDTH;
    localparam int KW      = COEFF_WIDTH;
    localparam int PROD_W  = CW + KW;
    localparam int CONST_W = KW + vptw_pkg::FRAC_BITS + 1;
    localparam int TERM_W  = (PROD_W > CONST_W) ? PROD_W : CONST_W;
    localparam int CLIP_W  = TERM_W + 2;
    localparam int MAG_W   = CLIP_W;
    localparam int NUM_W   = MAG_W + vptw_pkg::SIZE_W;
    localparam int ROW_PAD = (4 * KW > vptw_pkg::DATA_W) ? 4 * KW : vptw_pkg::DATA_W;
    localparam int FIN_W   = vptw_pkg::QUOT_W + 3;
    localparam int QW      = vptw_pkg::QUOT_W;
    localparam int DS      = vptw_pkg::DIV_STAGES;

    typedef struct packed {
        logic       fail;
        logic [2:0] neg;
    } tag_t;

    // ---------------- configuration registers ----------------
    logic [vptw_pkg::DATA_W-1:0] row_reg [4];
    logic [31:0]                 origin_reg;
    logic [31:0]                 size_reg;
    logic [vptw_pkg::EPS_W-1:0]  eps_reg;
    logic                        cfg_wr;
    vptw_pkg::cfg_reg_t          cfg_sel;

    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite;
    assign cfg_sel = vptw_pkg::cfg_reg_t'(paddr[vptw_pkg::ADDR_W-1:3]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_reg[0] <= 64'h0000_0000_0000_1000;
            row_reg[1] <= 64'h0000_0000_1000_0000;
            row_reg[2] <= 64'h0000_1000_0000_0000;
            row_reg[3] <= 64'h1000_0000_0000_0000;
            origin_reg <= 32'h0000_0000;
            size_reg   <= 32'h01E0_0280;   // 640 x 480
            eps_reg    <= 16'h0001;
        end else if (cfg_wr) begin
            case (cfg_sel)
                vptw_pkg::REG_ROW0:   row_reg[0] <= pwdata;
                vptw_pkg::REG_ROW1:   row_reg[1] <= pwdata;
                vptw_pkg::REG_ROW2:   row_reg[2] <= pwdata;
                vptw_pkg::REG_ROW3:   row_reg[3] <= pwdata;
                vptw_pkg::REG_ORIGIN: origin_reg <= pwdata[31:0];
                vptw_pkg::REG_SIZE:   size_reg   <= pwdata[31:0];
                vptw_pkg::REG_WEPS:   eps_reg    <= pwdata[vptw_pkg::EPS_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_sel)
            vptw_pkg::REG_ROW0:   prdata = row_reg[0];
            vptw_pkg::REG_ROW1:   prdata = row_reg[1];
            vptw_pkg::REG_ROW2:   prdata = row_reg[2];
            vptw_pkg::REG_ROW3:   prdata = row_reg[3];
            vptw_pkg::REG_ORIGIN: prdata = vptw_pkg::DATA_W'(origin_reg);
            vptw_pkg::REG_SIZE:   prdata = vptw_pkg::DATA_W'(size_reg);
            vptw_pkg::REG_WEPS:   prdata = vptw_pkg::DATA_W'(eps_reg);
            default:              prdata = '0;
        endcase
    end

    // coefficient unpack; columns past bit 63 read as zero
    logic [ROW_PAD-1:0]   row_pad [4];
    logic signed [KW-1:0] coeff_s [4][4];

    for (genvar r = 0; r < 4; r++) begin : g_row
        assign row_pad[r] = ROW_PAD'(row_reg[r]);
        for (genvar c = 0; c < 4; c++) begin : g_col
            assign coeff_s[r][c] = row_pad[r][c*KW +: KW];
        end
    end

    // ---------------- pipeline control ----------------
    // One global advance; the two-entry output buffer absorbs the item
    // that may land while m_ready is low.
    logic [1:0] cnt_reg;
    logic       adv;

    assign adv     = (cnt_reg != 2'd2);
    assign s_ready = adv;

    // stage 1: input
    logic                 v1_reg;
    logic signed [CW-1:0] pnt_reg [3];

    // stage 2: products
    logic                     v2_reg;
    logic signed [PROD_W-1:0] prod_reg [4][3];
    logic signed [KW-1:0]     wc_reg   [4];

    // stage 3: clip coordinates (Q.28)
    logic                     v3_reg;
    logic signed [CLIP_W-1:0] clip_reg [4];

    // stage 4: magnitudes, signs, near-zero w
    logic             v4_reg;
    logic [MAG_W-1:0] mag_reg [4];
    tag_t             tag4_reg;

    // stage 5: scaled numerators
    logic             v5_reg;
    logic [NUM_W-1:0] num_reg [3];
    logic [MAG_W-1:0] den_reg;
    tag_t             tag5_reg;

    // divider side band
    logic [DS-1:0] vdiv_reg;
    tag_t          tag_reg [DS];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            v3_reg   <= 1'b0;
            v4_reg   <= 1'b0;
            v5_reg   <= 1'b0;
            vdiv_reg <= '0;
        end else if (adv) begin
            v1_reg   <= s_valid;
            v2_reg   <= v1_reg;
            v3_reg   <= v2_reg;
            v4_reg   <= v3_reg;
            v5_reg   <= v4_reg;
            vdiv_reg <= {vdiv_reg[DS-2:0], v5_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            pnt_reg[0] <= s_point_x;
            pnt_reg[1] <= s_point_y;
            pnt_reg[2] <= s_point_z;

            for (int r = 0; r < 4; r++) begin
                for (int c = 0; c < 3; c++) begin
                    prod_reg[r][c] <= PROD_W'(coeff_s[r][c]) * PROD_W'(pnt_reg[c]);
                end
                wc_reg[r] <= coeff_s[r][3];
            end

            // constant column: coefficient times 1.0 in Q16.16
            for (int r = 0; r < 4; r++) begin
                clip_reg[r] <= CLIP_W'(prod_reg[r][0]) + CLIP_W'(prod_reg[r][1])
                             + CLIP_W'(prod_reg[r][2])
                             + (CLIP_W'(wc_reg[r]) <<< vptw_pkg::FRAC_BITS);
            end

            for (int r = 0; r < 4; r++) begin
                mag_reg[r] <= clip_reg[r][CLIP_W-1] ? MAG_W'(-clip_reg[r])
                                                    : MAG_W'(clip_reg[r]);
            end
            for (int r = 0; r < 3; r++) begin
                tag4_reg.neg[r] <= clip_reg[r][CLIP_W-1] ^ clip_reg[3][CLIP_W-1];
            end
            tag4_reg.fail <= ((clip_reg[3][CLIP_W-1] ? MAG_W'(-clip_reg[3])
                                                      : MAG_W'(clip_reg[3]))
                              <= MAG_W'({eps_reg, {vptw_pkg::EPS_SH{1'b0}}}));

            num_reg[0] <= NUM_W'(mag_reg[0]) * NUM_W'(size_reg[15:0]);
            num_reg[1] <= NUM_W'(mag_reg[1]) * NUM_W'(size_reg[31:16]);
            num_reg[2] <= NUM_W'(mag_reg[2]);
            den_reg    <= mag_reg[3];
            tag5_reg   <= tag4_reg;

            tag_reg[0] <= tag5_reg;
            for (int i = 1; i < DS; i++) begin
                tag_reg[i] <= tag_reg[i-1];
            end
        end
    end

    // ---------------- division lanes ----------------
    logic [QW-1:0] quot [3];
    logic          qsat [3];

    for (genvar l = 0; l < 3; l++) begin : g_lane
        vptw_div #(
            .MAG_W (MAG_W)
        ) u_div (
            .aclk   (aclk),
            .i_en   (adv),
            .i_num  (num_reg[l]),
            .i_den  (den_reg),
            .o_quot (quot[l]),
            .o_sat  (qsat[l])
        );
    end

    // origin*2^16 + size*2^15 +/- term, saturated to 32 bits
    function automatic logic [vptw_pkg::OUT_W-1:0] fin_map(
        input logic signed [15:0]            org,
        input logic [vptw_pkg::SIZE_W-1:0]   sz,
        input logic [QW-1:0]                 t,
        input logic                          neg
    );
        logic signed [FIN_W-1:0] base;
        logic signed [FIN_W-1:0] v;
        base = (FIN_W'(org) <<< vptw_pkg::FRAC_BITS)
             + $signed(FIN_W'(sz) << vptw_pkg::HALF_SH);
        v = neg ? base - $signed(FIN_W'(t)) : base + $signed(FIN_W'(t));
        if ((v[FIN_W-1:vptw_pkg::OUT_W-1] == '0) || (v[FIN_W-1:vptw_pkg::OUT_W-1] == '1)) begin
            fin_map = v[vptw_pkg::OUT_W-1:0];
        end else if (v[FIN_W-1]) begin
            fin_map = {1'b1, {(vptw_pkg::OUT_W-1){1'b0}}};
        end else begin
            fin_map = {1'b0, {(vptw_pkg::OUT_W-1){1'b1}}};
        end
    endfunction

    logic [QW-1:0]     term [3];
    tag_t              tag_last;
    vptw_pkg::result_t res_in;

    assign tag_last = tag_reg[DS-1];

    always_comb begin
        for (int l = 0; l < 3; l++) begin
            term[l] = (qsat[l] || (quot[l] > vptw_pkg::TERM_CAP)) ? vptw_pkg::TERM_CAP
                                                                  : quot[l];
        end
        if (tag_last.fail) begin
            res_in = '0;
        end else begin
            res_in.screen_x     = fin_map(origin_reg[15:0], size_reg[15:0],
                                          term[0], tag_last.neg[0]);
            res_in.screen_y     = fin_map(origin_reg[31:16], size_reg[31:16],
                                          term[1], tag_last.neg[1]);
            res_in.window_depth = fin_map(16'sd0, 16'd1, term[2], tag_last.neg[2]);
            res_in.projected_ok = 1'b1;
        end
    end

    // ---------------- output buffer ----------------
    vptw_pkg::result_t ent_reg [2];
    logic              wr_ptr_reg;
    logic              rd_ptr_reg;
    logic              push;
    logic              pop;
    vptw_pkg::result_t res_out;

    assign push = adv & vdiv_reg[DS-1];
    assign pop  = m_valid & m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg    <= 2'd0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end else begin
            if (push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (push && !pop) begin
                cnt_reg <= cnt_reg + 2'd1;
            end else if (pop && !push) begin
                cnt_reg <= cnt_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            ent_reg[wr_ptr_reg] <= res_in;
        end
    end

    assign res_out        = ent_reg[rd_ptr_reg];
    assign m_valid        = (cnt_reg != 2'd0);
    assign m_screen_x     = res_out.screen_x;
    assign m_screen_y     = res_out.screen_y;
    assign m_window_depth = res_out.window_depth;
    assign m_projected_ok = res_out.projected_ok;

    // ---------------- checks ----------------
    `VPTW_ASSERT_SAME(a_cnt_range, 1'b1, cnt_reg != 2'd3, "output buffer count out of range")
    `VPTW_ASSERT_NEXT(a_full_holds, (cnt_reg == 2'd2) && !m_ready, cnt_reg == 2'd2, "full buffer drained without pop")
    `VPTW_ASSERT_SAME(a_fail_zero, m_valid && !m_projected_ok, (m_screen_x == '0) && (m_screen_y == '0) && (m_window_depth == '0), "failed projection with nonzero coordinates")

endmodule

>>> design/vptw_div.sv
// ----------------------------------------------------------------------------
// vptw_div
// Pipelined restoring divider: trunc(num * 2^15 / den), one quotient bit per
// stage, with an up-front overflow check that flags the saturated case.
// ----------------------------------------------------------------------------
module vptw_div #(
    parameter int MAG_W = 50
) (
    input  logic                              aclk,
    input  logic                              i_en,
    input  logic [MAG_W+vptw_pkg::SIZE_W-1:0] i_num,
    input  logic [MAG_W-1:0]                  i_den,
    output logic [vptw_pkg::QUOT_W-1:0]       o_quot,
    output logic                              o_sat
);

    localparam int QW    = vptw_pkg::QUOT_W;
    localparam int LOW_W = vptw_pkg::NUM_SHIFT;
    localparam int CMP_W = MAG_W + LOW_W;

    logic [MAG_W-1:0] rem_reg  [QW];
    logic [MAG_W-1:0] den_reg  [QW];
    logic [LOW_W-1:0] low_reg  [QW];
    logic [QW-1:0]    quot_reg [QW+1];
    logic             sat_reg  [QW+1];

    logic [CMP_W-1:0] num_ext;
    logic [CMP_W-1:0] den_sh;

    // quotient would need more than QW bits
    assign num_ext = CMP_W'(i_num);
    assign den_sh  = {i_den, {LOW_W{1'b0}}};

    always_ff @(posedge aclk) begin
        if (i_en) begin
            rem_reg[0]  <= MAG_W'(i_num >> LOW_W);
            den_reg[0]  <= i_den;
            low_reg[0]  <= i_num[LOW_W-1:0];
            quot_reg[0] <= '0;
            sat_reg[0]  <= (num_ext >= den_sh);
        end
    end

    for (genvar k = 0; k < QW; k++) begin : g_step
        localparam int BIT_IDX = QW - 1 - k - vptw_pkg::HALF_SH;
        logic         in_bit;
        logic [MAG_W:0] trial;
        logic [MAG_W:0] diff;
        logic           ge;

        if (BIT_IDX >= 0) begin : g_bit
            assign in_bit = low_reg[k][BIT_IDX];
        end else begin : g_zero
            assign in_bit = 1'b0;
        end

        assign trial = {rem_reg[k], in_bit};
        assign diff  = trial - {1'b0, den_reg[k]};
        assign ge    = (trial >= {1'b0, den_reg[k]});

        always_ff @(posedge aclk) begin
            if (i_en) begin
                quot_reg[k+1] <= {quot_reg[k][QW-2:0], ge};
                sat_reg[k+1]  <= sat_reg[k];
            end
        end

        if (k < QW - 1) begin : g_carry
            always_ff @(posedge aclk) begin
                if (i_en) begin
                    rem_reg[k+1] <= ge ? diff[MAG_W-1:0] : trial[MAG_W-1:0];
                    den_reg[k+1] <= den_reg[k];
                    low_reg[k+1] <= low_reg[k];
                end
            end
        end
    end

    assign o_quot = quot_reg[QW];
    assign o_sat  = sat_reg[QW];

endmodule

>>> tb/sv/vertex_project_to_window_top_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// vertex_project_to_window_top_test
// Streams points through the projection pipeline and checks every window
// result against a fixed-point predictor, across several matrix, viewport
// and w_epsilon settings, with random sender gaps and receiver stalls.
// ----------------------------------------------------------------------------

// one window result: x, y, depth and the success flag
typedef struct {
    logic [31:0] wx;
    logic [31:0] wy;
    logic [31:0] wd;
    logic        ok;
} window_t;

// Holds the expected window results in arrival order.
class window_scoreboard;
    window_t pending[$];
    int      mismatches;

    function void note_point(window_t w);
        pending.push_back(w);
    endfunction

    function void check_window(logic [31:0] wx, logic [31:0] wy, logic [31:0] wd,
                               logic ok);
        window_t e;
        if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected result x=%h y=%h d=%h ok=%b", wx, wy, wd, ok);
            return;
        end
        e = pending.pop_front();
        if (e.wx !== wx || e.wy !== wy || e.wd !== wd || e.ok !== ok) begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch: exp x=%h y=%h d=%h ok=%b got x=%h y=%h d=%h ok=%b",
                         e.wx, e.wy, e.wd, e.ok, wx, wy, wd, ok);
        end
    endfunction
endclass

module vertex_project_to_window_top_test;

    localparam int LATENCY = 48;

    logic        aclk;
    logic        aresetn;
    logic        psel, penable, pwrite;
    logic [vptw_pkg::ADDR_W-1:0] paddr;
    logic [63:0] pwdata;
    logic [63:0] prdata;
    logic        pready;
    logic        s_valid, s_ready;
    logic signed [31:0] s_point_x, s_point_y, s_point_z;
    logic        m_valid, m_ready;
    logic signed [31:0] m_screen_x, m_screen_y, m_window_depth;
    logic        m_projected_ok;

    // shadow copy of the register file
    logic [63:0] mrow[4];
    logic [31:0] vp_origin, vp_size;
    logic [15:0] w_eps;

    window_scoreboard sb;
    bit          stalls_on;

    vertex_project_to_window_top dut (.*);

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // hard limit: far above the slowest correct run
    initial begin
        #20ms;
        $display("FAIL vertex_project_to_window_top");
        $finish;
    end

    // Q4.12 coefficient c of a row, sign extended
    function automatic logic signed [63:0] coef(logic [63:0] row, int c);
        return 64'(signed'(row[c*16 +: 16]));
    endfunction

    // trunc(num * 2^15 / den), capped at 2^40
    function automatic logic [63:0] scaled_quot(logic [63:0] num, logic [63:0] den);
        logic [127:0] q;
        q = ({64'd0, num} << 15) / {64'd0, den};
        return (q >= (128'd1 << 40)) ? (64'd1 << 40) : q[63:0];
    endfunction

    function automatic logic [31:0] to_window(logic signed [63:0] c, logic signed [63:0] w,
                                              logic signed [63:0] org, logic [63:0] sz);
        logic [63:0] mc, mw, t;
        logic signed [63:0] v;
        mc = c < 0 ? -c : c;
        mw = w < 0 ? -w : w;
        t  = scaled_quot(mc * sz, mw);
        v  = (org <<< 16) + signed'(sz << 15);
        if ((c < 0) != (w < 0)) v = v - signed'(t);
        else v = v + signed'(t);
        if (v > 64'sd2147483647) v = 64'sd2147483647;
        if (v < -64'sd2147483648) v = -64'sd2147483648;
        return v[31:0];
    endfunction

    function automatic window_t project_point(logic [31:0] x,
            logic [31:0] y, logic [31:0] z);
        window_t r;
        logic signed [63:0] p[3];
        logic signed [63:0] cl[4];
        logic [63:0] mw;
        p[0] = 64'(signed'(x));
        p[1] = 64'(signed'(y));
        p[2] = 64'(signed'(z));
        for (int i = 0; i < 4; i++)
            cl[i] = coef(mrow[i], 0) * p[0] + coef(mrow[i], 1) * p[1]
                  + coef(mrow[i], 2) * p[2] + (coef(mrow[i], 3) <<< 16);
        mw = cl[3] < 0 ? -cl[3] : cl[3];
        if (mw <= (64'(w_eps) << 12)) begin
            r.wx = '0; r.wy = '0; r.wd = '0; r.ok = 1'b0;
        end else begin
            r.wx = to_window(cl[0], cl[3], 64'(signed'(vp_origin[15:0])), 64'(vp_size[15:0]));
            r.wy = to_window(cl[1], cl[3], 64'(signed'(vp_origin[31:16])),
                             64'(vp_size[31:16]));
            r.wd = to_window(cl[2], cl[3], 64'sd0, 64'd1);
            r.ok = 1'b1;
        end
        return r;
    endfunction

    // setup and access cycle; the caller releases the bus after the last write
    task automatic write_reg(vptw_pkg::cfg_reg_t idx, logic [63:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= vptw_pkg::ADDR_W'(idx) << 3;
        pwdata  <= val;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        case (idx)
            vptw_pkg::REG_ROW0:   mrow[0] = val;
            vptw_pkg::REG_ROW1:   mrow[1] = val;
            vptw_pkg::REG_ROW2:   mrow[2] = val;
            vptw_pkg::REG_ROW3:   mrow[3] = val;
            vptw_pkg::REG_ORIGIN: vp_origin = val[31:0];
            vptw_pkg::REG_SIZE:   vp_size = val[31:0];
            vptw_pkg::REG_WEPS:   w_eps = val[15:0];
            default: ;
        endcase
    endtask

    task automatic load_setup(logic [63:0] r0, logic [63:0] r1, logic [63:0] r2,
                              logic [63:0] r3, logic [31:0] org, logic [31:0] sz,
                              logic [15:0] eps);
        write_reg(vptw_pkg::REG_ROW0, r0);
        write_reg(vptw_pkg::REG_ROW1, r1);
        write_reg(vptw_pkg::REG_ROW2, r2);
        write_reg(vptw_pkg::REG_ROW3, r3);
        write_reg(vptw_pkg::REG_ORIGIN, 64'(org));
        write_reg(vptw_pkg::REG_SIZE, 64'(sz));
        write_reg(vptw_pkg::REG_WEPS, 64'(eps));
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // one item; valid held until accepted; predictor updated at acceptance
    task automatic send_point(logic [31:0] x, logic [31:0] y, logic [31:0] z);
        s_valid   <= 1'b1;
        s_point_x <= x;
        s_point_y <= y;
        s_point_z <= z;
        do @(posedge aclk); while (!s_ready);
        sb.note_point(project_point(x, y, z));
    endtask

    // burst of random points with random gaps between bursts
    task automatic send_burst(int n, bit small_coords);
        logic [31:0] v[3];
        int          gap;
        for (int i = 0; i < n; i++) begin
            for (int k = 0; k < 3; k++)
                v[k] = small_coords ? 32'(signed'($urandom_range(0, 2**22) - 2**21))
                                    : $urandom;
            send_point(v[0], v[1], v[2]);
        end
        gap = $urandom_range(0, 6);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic drain;
        s_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (LATENCY + 4) @(posedge aclk);
    endtask

    function automatic logic [63:0] rand_row(int r);
        logic [63:0] row;
        for (int c = 0; c < 4; c++)
            row[c*16 +: 16] = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                            : 16'(signed'($urandom_range(0, 8192) - 4096));
        // keep w mostly away from zero
        if (r == 3 && $urandom_range(0, 3) != 0) row[63:48] = 16'h1000;
        return row;
    endfunction

    // receiver: stall pattern, switched off during some phases
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= !stalls_on || ($urandom_range(0, 3) != 0);
            if (m_valid && m_ready)
                sb.check_window(m_screen_x, m_screen_y, m_window_depth, m_projected_ok);
        end
    end

    initial begin
        sb = new();
        aresetn = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        s_valid = 1'b0; s_point_x = '0; s_point_y = '0; s_point_z = '0;
        stalls_on = 1'b0;
        mrow[0] = 64'h1000;
        mrow[1] = 64'h1000 << 16;
        mrow[2] = 64'h1000 << 32;
        mrow[3] = 64'h1000 << 48;
        vp_origin = '0;
        vp_size = 32'd31457920;
        w_eps = 16'd1;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: reset identity with w fixed at 1, field extremes
        send_point(32'h0, 32'h0, 32'h0);
        send_point(32'h0001_0000, 32'hFFFF_0000, 32'h0000_8000);
        send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF);
        send_point(32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0001);
        drain();

        // w taken from z: zero w, tiny w at the epsilon edge, huge quotient
        load_setup(64'h1000, 64'h1000 << 16, 64'h1000 << 32, 64'h1000 << 32,
                   32'h8000_7FFF, 32'hFFFF_FFFF, 16'hFFFF);
        send_point(32'h1234_0000, 32'h0, 32'h0);
        send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_FFFF);
        send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000);
        send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000);
        send_point(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        drain();

        // zero viewport, extreme coefficients, zero epsilon
        load_setup(64'h8000_7FFF_8000_7FFF, 64'hFFFF_FFFF_FFFF_FFFF,
                   64'h7FFF_8000_7FFF_8000, 64'h1000_0001_FFFF_0000,
                   32'h7FFF_8000, 32'h0, 16'h0);
        send_point(32'h0, 32'h0, 32'h0);
        send_point(32'h0001_0000, 32'h0002_0000, 32'h0003_0000);
        send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        drain();

        // random phases with new settings each time
        for (int ph = 0; ph < 8; ph++) begin
            load_setup(rand_row(0), rand_row(1), rand_row(2), rand_row(3),
                       $urandom, (ph == 7) ? 32'hFFFF_FFFF : $urandom,
                       (ph == 6) ? 16'hFFFF : 16'($urandom_range(0, 64)));
            stalls_on = (ph % 3) != 0;
            for (int n = 0; n < 200; ) begin
                int len;
                len = $urandom_range(1, 24);
                send_burst(len, $urandom_range(0, 2) != 0);
                n += len;
            end
            drain();
        end

        if (sb.mismatches == 0 && sb.pending.size() == 0)
            $display("PASS vertex_project_to_window_top");
        else
            $display("FAIL vertex_project_to_window_top");
        $finish;
    end
endmodule

>>> sim.f
+incdir+design
design/vptw_pkg.sv
design/vptw_div.sv
design/vertex_project_to_window_top.sv
tb/sv/vertex_project_to_window_top_test.sv
